// File: rtl/core/stxrx_pkg.sv
package stxrx_pkg;

    // FIFO geometry
    localparam int TX_DEPTH = 512;
    localparam int RX_DEPTH = 512;
    localparam int TX_AW    = $clog2(TX_DEPTH);
    localparam int RX_AW    = $clog2(RX_DEPTH);
    localparam int TX_FW    = $clog2(TX_DEPTH + 1);
    localparam int RX_FW    = $clog2(RX_DEPTH + 1);

    // item field widths
    localparam int BYTE_W   = 8;
    localparam int LEVEL_W  = 10;

    localparam logic [BYTE_W-1:0] BYTE_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] BYTE_CR = 8'h0D;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_TX_TAKE = 2'd1,
        OP_RX_PUT  = 2'd2,
        OP_RX_READ = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_NOCAP = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WR_LF,
        ST_RD_WAIT
    } t_state;

    // one result item
    typedef struct packed {
        logic [BYTE_W-1:0]  read_data;
        t_status            status;
        logic               cr_inserted;
        logic [LEVEL_W-1:0] tx_level;
        logic [LEVEL_W-1:0] rx_level;
    } t_result;

    // memory port requests
    typedef struct packed {
        logic              we;
        logic [TX_AW-1:0]  waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [TX_AW-1:0]  raddr;
    } t_tx_req;

    typedef struct packed {
        logic              we;
        logic [RX_AW-1:0]  waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [RX_AW-1:0]  raddr;
    } t_rx_req;

endpackage

// File: rtl/core/stxrx_ram.sv
module stxrx_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// File: rtl/core/stxrx_obuf.sv
module stxrx_obuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  stxrx_pkg::t_result i_result,
    output logic             o_can_load,
    output logic             o_valid,
    input  logic             i_stall,
    output stxrx_pkg::t_result o_result
);
    import stxrx_pkg::*;

    logic    r_valid;
    t_result r_result;

    // free when empty or being taken this cycle
    assign o_can_load = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

`ifndef NO_ASSERTIONS
    ap_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_stall |-> !i_load)
        else $error("result item overwritten while stalled");
`endif

endmodule

// File: rtl/core/stxrx_ctrl.sv
module stxrx_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_operation,
    input  logic [stxrx_pkg::BYTE_W-1:0]    i_data_byte,
    input  logic                            i_start_of_write,
    output stxrx_pkg::t_tx_req              o_tx_req,
    input  logic [stxrx_pkg::BYTE_W-1:0]    i_tx_rdata,
    output stxrx_pkg::t_rx_req              o_rx_req,
    input  logic [stxrx_pkg::BYTE_W-1:0]    i_rx_rdata,
    input  logic                            i_can_load,
    output logic                            o_res_load,
    output stxrx_pkg::t_result              o_result
);
    import stxrx_pkg::*;

    t_state            r_state, n_state;
    logic [TX_AW-1:0]  r_tx_wp, n_tx_wp, r_tx_rp, n_tx_rp;
    logic [TX_FW-1:0]  r_tx_fill, n_tx_fill;
    logic [RX_AW-1:0]  r_rx_wp, n_rx_wp, r_rx_rp, n_rx_rp;
    logic [RX_FW-1:0]  r_rx_fill, n_rx_fill;
    logic [BYTE_W-1:0] r_prev, n_prev;
    logic              r_refused, n_refused;
    logic              r_cap;
    logic              r_rd_rx;

    t_op               op;
    logic              accept;
    logic [BYTE_W-1:0] prev_eff;
    logic              refused_eff;
    logic              tx_full, rx_full;
    logic              ins_cr, take_tx, take_rx;
    logic [TX_AW-1:0]  tx_wp_inc, tx_rp_inc;
    logic [RX_AW-1:0]  rx_wp_inc, rx_rp_inc;

    assign op         = t_op'(i_operation);
    assign accept     = i_in_valid && (r_state == ST_IDLE) && i_can_load;
    assign o_in_stall = !((r_state == ST_IDLE) && i_can_load);

    // wrapping pointer increments
    assign tx_wp_inc = (r_tx_wp == TX_AW'(TX_DEPTH - 1)) ? '0 : r_tx_wp + 1'b1;
    assign tx_rp_inc = (r_tx_rp == TX_AW'(TX_DEPTH - 1)) ? '0 : r_tx_rp + 1'b1;
    assign rx_wp_inc = (r_rx_wp == RX_AW'(RX_DEPTH - 1)) ? '0 : r_rx_wp + 1'b1;
    assign rx_rp_inc = (r_rx_rp == RX_AW'(RX_DEPTH - 1)) ? '0 : r_rx_rp + 1'b1;

    // item decode against current state
    always_comb begin
        prev_eff    = i_start_of_write ? '0 : r_prev;
        refused_eff = i_start_of_write ? 1'b0 : r_refused;
        tx_full     = (r_tx_fill == TX_FW'(TX_DEPTH));
        rx_full     = (r_rx_fill == RX_FW'(RX_DEPTH));
        ins_cr      = (op == OP_WRITE) && !refused_eff && !tx_full
                      && (i_data_byte == BYTE_LF) && (prev_eff != BYTE_CR)
                      && (r_tx_fill < TX_FW'(TX_DEPTH - 1));
        take_tx     = (op == OP_TX_TAKE) && (r_tx_fill != '0);
        take_rx     = (op == OP_RX_READ) && (r_rx_fill != '0);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && ins_cr) begin
                    n_state = ST_WR_LF;
                end else if (accept && (take_tx || take_rx)) begin
                    n_state = ST_RD_WAIT;
                end
            end
            ST_WR_LF:   n_state = ST_IDLE;
            ST_RD_WAIT: n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // datapath, memory requests and result
    always_comb begin
        n_tx_wp   = r_tx_wp;
        n_tx_rp   = r_tx_rp;
        n_tx_fill = r_tx_fill;
        n_rx_wp   = r_rx_wp;
        n_rx_rp   = r_rx_rp;
        n_rx_fill = r_rx_fill;
        n_prev    = r_prev;
        n_refused = r_refused;
        o_tx_req  = '0;
        o_rx_req  = '0;
        o_res_load = 1'b0;
        o_result  = '0;
        o_result.status = STAT_DONE;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (op)
                        OP_WRITE: begin
                            n_prev    = prev_eff;
                            n_refused = refused_eff;
                            if (refused_eff) begin
                                o_result.status = STAT_FULL;
                                o_res_load = 1'b1;
                            end else if (tx_full) begin
                                n_refused = 1'b1;
                                o_result.status = STAT_FULL;
                                o_res_load = 1'b1;
                            end else begin
                                // CR goes first; the line feed follows next cycle
                                o_tx_req.we    = 1'b1;
                                o_tx_req.waddr = r_tx_wp;
                                o_tx_req.wdata = ins_cr ? BYTE_CR : i_data_byte;
                                n_tx_wp   = tx_wp_inc;
                                n_tx_fill = r_tx_fill + 1'b1;
                                if (!ins_cr) begin
                                    n_prev     = i_data_byte;
                                    o_res_load = 1'b1;
                                end
                            end
                        end
                        OP_TX_TAKE: begin
                            if (take_tx) begin
                                o_tx_req.re    = 1'b1;
                                o_tx_req.raddr = r_tx_rp;
                                n_tx_rp   = tx_rp_inc;
                                n_tx_fill = r_tx_fill - 1'b1;
                            end else begin
                                o_result.status = STAT_EMPTY;
                                o_res_load = 1'b1;
                            end
                        end
                        OP_RX_PUT: begin
                            o_res_load = 1'b1;
                            if (!r_cap) begin
                                o_result.status = STAT_NOCAP;
                            end else if (rx_full) begin
                                o_result.status = STAT_FULL;
                            end else begin
                                o_rx_req.we    = 1'b1;
                                o_rx_req.waddr = r_rx_wp;
                                o_rx_req.wdata = i_data_byte;
                                n_rx_wp   = rx_wp_inc;
                                n_rx_fill = r_rx_fill + 1'b1;
                            end
                        end
                        OP_RX_READ: begin
                            if (take_rx) begin
                                o_rx_req.re    = 1'b1;
                                o_rx_req.raddr = r_rx_rp;
                                n_rx_rp   = rx_rp_inc;
                                n_rx_fill = r_rx_fill - 1'b1;
                            end else begin
                                o_result.status = STAT_EMPTY;
                                o_res_load = 1'b1;
                            end
                        end
                        default: begin
                            o_res_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_WR_LF: begin
                o_tx_req.we    = 1'b1;
                o_tx_req.waddr = r_tx_wp;
                o_tx_req.wdata = BYTE_LF;
                n_tx_wp   = tx_wp_inc;
                n_tx_fill = r_tx_fill + 1'b1;
                n_prev    = BYTE_LF;
                o_result.cr_inserted = 1'b1;
                o_res_load = 1'b1;
            end
            ST_RD_WAIT: begin
                o_result.read_data = r_rd_rx ? i_rx_rdata : i_tx_rdata;
                o_res_load = 1'b1;
            end
            default: begin
                o_res_load = 1'b0;
            end
        endcase

        // levels after this item
        o_result.tx_level = LEVEL_W'(n_tx_fill);
        o_result.rx_level = LEVEL_W'(n_rx_fill);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_tx_wp   <= '0;
            r_tx_rp   <= '0;
            r_tx_fill <= '0;
            r_rx_wp   <= '0;
            r_rx_rp   <= '0;
            r_rx_fill <= '0;
            r_prev    <= '0;
            r_refused <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_tx_wp   <= n_tx_wp;
            r_tx_rp   <= n_tx_rp;
            r_tx_fill <= n_tx_fill;
            r_rx_wp   <= n_rx_wp;
            r_rx_rp   <= n_rx_rp;
            r_rx_fill <= n_rx_fill;
            r_prev    <= n_prev;
            r_refused <= n_refused;
        end
    end

    // capture enable register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= 1'b1;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    // which FIFO a pending read came from
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_rx <= (op == OP_RX_READ);
        end
    end

`ifndef NO_ASSERTIONS
    ap_tx_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_fill <= TX_FW'(TX_DEPTH))
        else $error("transmit fill beyond depth");
    ap_rx_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rx_fill <= RX_FW'(RX_DEPTH))
        else $error("receive fill beyond depth");
    ap_lf_follows_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && ins_cr |=> o_tx_req.we && (o_tx_req.wdata == BYTE_LF) && o_res_load)
        else $error("line feed not written after inserted carriage return");
    ap_read_completes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (take_tx || take_rx) |=> (r_state == ST_RD_WAIT) && o_res_load)
        else $error("read item did not complete on the following cycle");
    ap_load_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_load |-> i_can_load)
        else $error("result loaded while output register is busy");
`endif

endmodule

// File: rtl/core/serial_tx_rx_fifo_crlf.sv
// Serial port transmit/receive byte FIFOs with line feed to CR-LF expansion.
// Writes and received bytes are loaded into the result output register as they are accepted;
// reads (registered RAM read) and LFs that get a CR inserted (one RAM write port per FIFO)
// load their result from ST_RD_WAIT or ST_WR_LF and hold off the next item while there.
// Throughput: 1 item/cycle otherwise; a stalled result holds off the next item until taken.
// Reset (synchronous, active low) empties both FIFOs and enables capture; RAM is not cleared.
module serial_tx_rx_fifo_crlf (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_of_write,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_read_data,
    output logic [1:0]  o_status,
    output logic        o_cr_inserted,
    output logic [9:0]  o_tx_level,
    output logic [9:0]  o_rx_level
);
    import stxrx_pkg::*;

    t_tx_req           tx_req;
    t_rx_req           rx_req;
    logic [BYTE_W-1:0] tx_rdata, rx_rdata;
    logic              can_load, res_load;
    t_result           res_d, res_q;

    // transmit FIFO storage
    stxrx_ram #(.DEPTH(TX_DEPTH), .WIDTH(BYTE_W)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_req.we),
        .i_waddr (tx_req.waddr),
        .i_wdata (tx_req.wdata),
        .i_re    (tx_req.re),
        .i_raddr (tx_req.raddr),
        .o_rdata (tx_rdata)
    );

    // receive FIFO storage
    stxrx_ram #(.DEPTH(RX_DEPTH), .WIDTH(BYTE_W)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_req.we),
        .i_waddr (rx_req.waddr),
        .i_wdata (rx_req.wdata),
        .i_re    (rx_req.re),
        .i_raddr (rx_req.raddr),
        .o_rdata (rx_rdata)
    );

    // pointers, fills and sequencing
    stxrx_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_data_byte      (i_data_byte),
        .i_start_of_write (i_start_of_write),
        .o_tx_req         (tx_req),
        .i_tx_rdata       (tx_rdata),
        .o_rx_req         (rx_req),
        .i_rx_rdata       (rx_rdata),
        .i_can_load       (can_load),
        .o_res_load       (res_load),
        .o_result         (res_d)
    );

    // result output register
    stxrx_obuf u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (res_load),
        .i_result   (res_d),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_result   (res_q)
    );

    assign o_read_data   = res_q.read_data;
    assign o_status      = res_q.status;
    assign o_cr_inserted = res_q.cr_inserted;
    assign o_tx_level    = res_q.tx_level;
    assign o_rx_level    = res_q.rx_level;

endmodule

// File: tb/sv/tb_serial_tx_rx_fifo_crlf.sv
`timescale 1ns / 1ps

module tb_serial_tx_rx_fifo_crlf;
    import stxrx_pkg::*;

    // Tracks both byte FIFOs and the CR-LF rule, queues the result each item should give
    class fifo_scoreboard;
        logic [BYTE_W-1:0] tx_mem [TX_DEPTH];
        logic [BYTE_W-1:0] rx_mem [RX_DEPTH];
        int                tx_wr;
        int                tx_rd;
        int                tx_cnt;
        int                rx_wr;
        int                rx_rd;
        int                rx_cnt;
        logic [BYTE_W-1:0] last_written;
        bit                write_blocked;
        bit                capture_on;
        t_result           due_results [$];
        int                mismatches;
        int                tx_refusals;
        int                rx_overflows;

        function new();
            tx_wr         = 0;
            tx_rd         = 0;
            tx_cnt        = 0;
            rx_wr         = 0;
            rx_rd         = 0;
            rx_cnt        = 0;
            last_written  = '0;
            write_blocked = 1'b0;
            capture_on    = 1'b1;
            mismatches    = 0;
            tx_refusals   = 0;
            rx_overflows  = 0;
        endfunction

        function void tx_store_byte(logic [BYTE_W-1:0] b);
            tx_mem[tx_wr] = b;
            tx_wr = (tx_wr + 1) % TX_DEPTH;
            tx_cnt++;
        endfunction

        // apply one accepted item and queue its result
        function void note_item(t_op op, logic [BYTE_W-1:0] b, logic first);
            t_result r;
            r = '0;
            r.status = STAT_DONE;
            case (op)
                OP_WRITE: begin
                    if (first) begin
                        last_written  = '0;
                        write_blocked = 1'b0;
                    end
                    if (write_blocked) begin
                        r.status = STAT_FULL;
                        tx_refusals++;
                    end else if (tx_cnt >= TX_DEPTH) begin
                        write_blocked = 1'b1;
                        r.status = STAT_FULL;
                        tx_refusals++;
                    end else begin
                        // bare LF gets a CR in front, if two slots are free
                        if (b == BYTE_LF && last_written != BYTE_CR
                            && tx_cnt + 1 < TX_DEPTH) begin
                            tx_store_byte(BYTE_CR);
                            r.cr_inserted = 1'b1;
                        end
                        tx_store_byte(b);
                        last_written = b;
                    end
                end
                OP_TX_TAKE: begin
                    if (tx_cnt == 0) begin
                        r.status = STAT_EMPTY;
                    end else begin
                        r.read_data = tx_mem[tx_rd];
                        tx_rd = (tx_rd + 1) % TX_DEPTH;
                        tx_cnt--;
                    end
                end
                OP_RX_PUT: begin
                    if (!capture_on) begin
                        r.status = STAT_NOCAP;
                    end else if (rx_cnt >= RX_DEPTH) begin
                        r.status = STAT_FULL;
                        rx_overflows++;
                    end else begin
                        rx_mem[rx_wr] = b;
                        rx_wr = (rx_wr + 1) % RX_DEPTH;
                        rx_cnt++;
                    end
                end
                default: begin
                    if (rx_cnt == 0) begin
                        r.status = STAT_EMPTY;
                    end else begin
                        r.read_data = rx_mem[rx_rd];
                        rx_rd = (rx_rd + 1) % RX_DEPTH;
                        rx_cnt--;
                    end
                end
            endcase
            r.tx_level = LEVEL_W'(tx_cnt);
            r.rx_level = LEVEL_W'(rx_cnt);
            due_results.push_back(r);
        endfunction

        task report_mismatch(string msg);
            if (mismatches < 50)
                $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        // compare one accepted result with the oldest expectation
        task check_result(t_result got);
            t_result want;
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", got));
                return;
            end
            want = due_results.pop_front();
            if (got.read_data !== want.read_data)
                report_mismatch($sformatf("read_data %h, want %h",
                                          got.read_data, want.read_data));
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.cr_inserted !== want.cr_inserted)
                report_mismatch($sformatf("cr_inserted %b, want %b",
                                          got.cr_inserted, want.cr_inserted));
            if (got.tx_level !== want.tx_level)
                report_mismatch($sformatf("tx_level %0d, want %0d",
                                          got.tx_level, want.tx_level));
            if (got.rx_level !== want.rx_level)
                report_mismatch($sformatf("rx_level %0d, want %0d",
                                          got.rx_level, want.rx_level));
        endtask
    endclass

    localparam int STUCK_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_operation;
    logic [7:0]  i_data_byte;
    logic        i_start_of_write;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_read_data;
    logic [1:0]  o_status;
    logic        o_cr_inserted;
    logic [9:0]  o_tx_level;
    logic [9:0]  o_rx_level;

    fifo_scoreboard sb = new();
    t_result        sink_result;
    bit             idling_on;
    int             stall_left;
    int             stuck_cycles;

    serial_tx_rx_fifo_crlf dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_data_byte      (i_data_byte),
        .i_start_of_write (i_start_of_write),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_read_data      (o_read_data),
        .o_status         (o_status),
        .o_cr_inserted    (o_cr_inserted),
        .o_tx_level       (o_tx_level),
        .o_rx_level       (o_rx_level)
    );

    // clock, 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    assign sink_result = {o_read_data, o_status, o_cr_inserted, o_tx_level, o_rx_level};

    // result side: check each accepted item
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(sink_result);
    end

    // result side stall bursts, started at random while idling is on
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (idling_on && $urandom_range(0, 4) == 0) begin
            stall_left  <= $urandom_range(0, 7);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // watchdog: no handshake on either side for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STUCK_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // LF-heavy byte mix for software writes
    function automatic logic [7:0] pick_write_byte();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel < 2)
            return BYTE_LF;
        else if (sel == 2)
            return BYTE_CR;
        return 8'($urandom_range(0, 255));
    endfunction

    // present one item, hold it until accepted; called and returns at a falling edge
    task automatic send_item(t_op op, logic [7:0] b, logic first);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        i_operation      = op;
        i_data_byte      = b;
        i_start_of_write = first;
        i_in_valid       = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_item(op, b, first);
        @(negedge i_clk);
    endtask

    task automatic stop_sending();
        i_in_valid = 1'b0;
    endtask

    task automatic drain_results();
        stop_sending();
        while (sb.due_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // capture enable write, only with the block idle
    task automatic set_capture(bit en);
        drain_results();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = en;
        @(posedge i_clk);
        sb.capture_on = en;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic random_item(int w_write, int w_take, int w_put, int w_read);
        int pick;
        pick = $urandom_range(0, w_write + w_take + w_put + w_read - 1);
        if (pick < w_write)
            send_item(OP_WRITE, pick_write_byte(), $urandom_range(0, 3) == 0);
        else if (pick < w_write + w_take)
            send_item(OP_TX_TAKE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        else if (pick < w_write + w_take + w_put)
            send_item(OP_RX_PUT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        else
            send_item(OP_RX_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // one write step toward a full transmit FIFO, steering through its corner cases
    task automatic fill_tx_step();
        if (sb.tx_cnt >= TX_DEPTH)
            send_item(OP_WRITE, pick_write_byte(), $urandom_range(0, 3) == 0);
        else if (sb.tx_cnt == TX_DEPTH - 1)
            send_item(OP_WRITE, BYTE_LF, 1'b1);
        else if (sb.tx_cnt == TX_DEPTH - 2)
            send_item(OP_WRITE, 8'($urandom_range(8'h10, 8'hFF)), 1'b0);
        else if ($urandom_range(0, 3) == 0)
            send_item(OP_WRITE, pick_write_byte(), $urandom_range(0, 7) == 0);
        else
            send_item(OP_WRITE, BYTE_LF, $urandom_range(0, 7) == 0);
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = 1'b0;
        i_in_valid       = 1'b0;
        i_operation      = OP_WRITE;
        i_data_byte      = '0;
        i_start_of_write = 1'b0;
        i_out_stall      = 1'b0;
        stall_left       = 0;
        stuck_cycles     = 0;
        idling_on        = 1'b1;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty takes, CR-LF rules, byte extremes, capture off
        send_item(OP_TX_TAKE, 8'h00, 1'b1);
        send_item(OP_RX_READ, 8'hFF, 1'b0);
        send_item(OP_WRITE, 8'h00, 1'b1);
        send_item(OP_WRITE, BYTE_LF, 1'b0);
        send_item(OP_WRITE, BYTE_CR, 1'b0);
        send_item(OP_WRITE, BYTE_LF, 1'b0);
        send_item(OP_WRITE, BYTE_CR, 1'b1);
        send_item(OP_WRITE, BYTE_LF, 1'b1);
        send_item(OP_WRITE, 8'hFF, 1'b0);
        repeat (10) send_item(OP_TX_TAKE, 8'hA5, 1'b0);
        send_item(OP_RX_PUT, 8'h00, 1'b1);
        send_item(OP_RX_PUT, 8'hFF, 1'b0);
        send_item(OP_RX_PUT, BYTE_LF, 1'b0);
        repeat (4) send_item(OP_RX_READ, 8'h00, 1'b0);
        set_capture(1'b0);
        send_item(OP_RX_PUT, 8'h5A, 1'b0);
        send_item(OP_RX_READ, 8'h00, 1'b0);
        set_capture(1'b1);

        // random mix, idling switched per stretch
        repeat (4) begin
            idling_on = ($urandom_range(0, 2) != 0);
            repeat (25) random_item(3, 2, 3, 2);
        end

        // push both FIFOs to full and past it
        idling_on = 1'b1;
        while (sb.tx_refusals < 3 || sb.rx_overflows < 3) begin
            if ($urandom_range(0, 31) == 0)
                random_item(0, 1, 0, 1);
            else if (sb.tx_refusals >= 3)
                send_item(OP_RX_PUT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else if (sb.rx_overflows >= 3)
                fill_tx_step();
            else if ($urandom_range(0, 9) < 6)
                send_item(OP_RX_PUT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else
                fill_tx_step();
        end

        // capture off while draining, then back on with no idling
        set_capture(1'b0);
        repeat (30) random_item(2, 3, 3, 3);
        set_capture(1'b1);
        idling_on = 1'b0;
        repeat (50) random_item(3, 3, 3, 3);

        drain_results();
        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
